>>> src/grid_bucket_nearest_point_top_defines.svh
// Assertion macros shared by the grid bucket checker.
`ifndef GRID_BUCKET_NEAREST_POINT_TOP_DEFINES_SVH
`define GRID_BUCKET_NEAREST_POINT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define GBNP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define GBNP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/gbnp_pkg.sv
// Shared constants, codes and types of the grid bucket nearest-point block.
package gbnp_pkg;

  localparam int GRID_MAX_DEF     = 64;
  localparam int BUCKET_DEPTH_DEF = 8;

  localparam int COORD_W    = 16;
  localparam int SCALE_W    = 16;
  localparam int ID_W       = 16;
  localparam int KIND_W     = 2;
  localparam int OP_W       = 2;
  localparam int STAT_W     = 2;
  localparam int DIST_W     = 33;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int PROD_W     = COORD_W + SCALE_W;
  localparam int CELL_SHIFT = 20;
  localparam int CELL_W     = PROD_W - CELL_SHIFT;
  localparam int GRID_REG_W = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd2;

  localparam logic [SCALE_W-1:0]    SCALE_RST = 16'd2048;
  localparam logic [GRID_REG_W-1:0] COLS_RST  = 7'd8;
  localparam logic [GRID_REG_W-1:0] ROWS_RST  = 7'd8;

  typedef struct packed {
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [ID_W-1:0]    id;
    logic [KIND_W-1:0]  kind;
  } entry_t;

  typedef struct packed {
    logic              found;
    logic [DIST_W-1:0] dsq;
    entry_t            ent;
  } best_t;

endpackage

>>> src/gbnp_if.sv
// Valid/ready channel interfaces for operation beats and result beats.
interface gbnp_in_if;
  logic                           valid;
  logic                           ready;
  logic [gbnp_pkg::OP_W-1:0]      operation;
  logic [gbnp_pkg::COORD_W-1:0]   pos_x;
  logic [gbnp_pkg::COORD_W-1:0]   pos_y;
  logic [gbnp_pkg::ID_W-1:0]      point_id;
  logic [gbnp_pkg::KIND_W-1:0]    end_kind;

  modport source(output valid, operation, pos_x, pos_y, point_id, end_kind, input ready);
  modport sink(input valid, operation, pos_x, pos_y, point_id, end_kind, output ready);
endinterface

interface gbnp_out_if;
  logic                           valid;
  logic                           ready;
  logic [gbnp_pkg::STAT_W-1:0]    status;
  logic                           found;
  logic [gbnp_pkg::ID_W-1:0]      nearest_id;
  logic [gbnp_pkg::KIND_W-1:0]    nearest_end;
  logic [gbnp_pkg::COORD_W-1:0]   nearest_x;
  logic [gbnp_pkg::COORD_W-1:0]   nearest_y;
  logic [gbnp_pkg::DIST_W-1:0]    dist_sq;

  modport source(output valid, status, found, nearest_id, nearest_end, nearest_x,
                 nearest_y, dist_sq, input ready);
  modport sink(input valid, status, found, nearest_id, nearest_end, nearest_x,
               nearest_y, dist_sq, output ready);
endinterface

>>> src/gbnp_mod_unit.sv
// Shared iterative remainder unit: cell index modulo the grid size, one bit per cycle.
module gbnp_mod_unit #(
  parameter int GRID_MAX = gbnp_pkg::GRID_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [gbnp_pkg::CELL_W-1:0]   dividend,
  input  logic [$clog2(GRID_MAX+1)-1:0] divisor,
  output logic                          done,
  output logic [$clog2(GRID_MAX+1)-1:0] rem
);

  localparam int CW   = $clog2(GRID_MAX + 1);
  localparam int CNTW = $clog2(gbnp_pkg::CELL_W + 1);

  logic [CW-1:0]               rem_r, rem_nxt;
  logic [CW-1:0]               div_r;
  logic [gbnp_pkg::CELL_W-1:0] quo_r;
  logic [CNTW-1:0]             cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [CW:0]                 trial;

  always_comb begin
    trial = {rem_r, quo_r[gbnp_pkg::CELL_W-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = CW'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = CW'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(gbnp_pkg::CELL_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNTW'(1);
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[gbnp_pkg::CELL_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> src/gbnp_dist.sv
// Distance pipeline: squares one stored point per cycle and keeps the running best.
module gbnp_dist (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic                         ent_vld,
  input  gbnp_pkg::entry_t             ent,
  input  logic [gbnp_pkg::COORD_W-1:0] qx,
  input  logic [gbnp_pkg::COORD_W-1:0] qy,
  output logic                         busy,
  output gbnp_pkg::best_t              best
);

  logic [gbnp_pkg::COORD_W-1:0] dxm, dym;
  logic [gbnp_pkg::SQ_W-1:0]    sqx_r, sqy_r;
  gbnp_pkg::entry_t             ent2_r;
  logic                         v2_r;
  logic [gbnp_pkg::DIST_W-1:0]  sum;
  gbnp_pkg::best_t              best_r;

  always_comb begin
    dxm = (qx >= ent.px) ? qx - ent.px : ent.px - qx;
    dym = (qy >= ent.py) ? qy - ent.py : ent.py - qy;
    sum = {1'b0, sqx_r} + {1'b0, sqy_r};
  end

  always_ff @(posedge clk) begin
    sqx_r  <= dxm * dxm;
    sqy_r  <= dym * dym;
    ent2_r <= ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r   <= 1'b0;
      best_r <= '0;
    end else begin
      v2_r <= ent_vld;
      if (clear) begin
        best_r <= '0;
      end else if (v2_r && (!best_r.found || sum < best_r.dsq)) begin
        // Only a strictly smaller distance replaces, so the first point met wins ties.
        best_r.found <= 1'b1;
        best_r.dsq   <= sum;
        best_r.ent   <= ent2_r;
      end
    end
  end

  assign busy = v2_r;
  assign best = best_r;

endmodule

>>> src/grid_bucket_nearest_point_top.sv
// Grid bucket point table: sequencer, fill-count and entry memories, config registers.
// Each accepted beat: cell index, dispatch, then an insert (fill-count read, then write),
// a clear of every fill count, or a find; an unused op or an insert outside the grid goes
// straight to the result. One item at a time; a find runs two remainder passes, x then y,
// then reads the fill count of each of the 3x3 cells and scans its entries newest first.
// Sync active-low reset clears control and config, then clears all fill counts, in_ch.ready low.
module grid_bucket_nearest_point_top #(
  parameter int GRID_MAX     = gbnp_pkg::GRID_MAX_DEF,
  parameter int BUCKET_DEPTH = gbnp_pkg::BUCKET_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gbnp_in_if.sink                         in_ch,
  gbnp_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [gbnp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbnp_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int GW     = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int CW     = $clog2(GRID_MAX + 1);
  localparam int SW     = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FW     = $clog2(BUCKET_DEPTH + 1);
  localparam int FAW    = 2 * GW;
  localparam int EAW    = FAW + SW;
  localparam int FDEPTH = 1 << FAW;
  localparam int EDEPTH = 1 << EAW;

  localparam int SWID = 4;
  localparam logic [SWID-1:0] S_IDLE   = 4'd0;
  localparam logic [SWID-1:0] S_CLR    = 4'd1;
  localparam logic [SWID-1:0] S_CELL   = 4'd2;
  localparam logic [SWID-1:0] S_DISP   = 4'd3;
  localparam logic [SWID-1:0] S_INS_RD = 4'd4;
  localparam logic [SWID-1:0] S_INS_WR = 4'd5;
  localparam logic [SWID-1:0] S_MODX   = 4'd6;
  localparam logic [SWID-1:0] S_MODY   = 4'd7;
  localparam logic [SWID-1:0] S_BK_RD  = 4'd8;
  localparam logic [SWID-1:0] S_BK_CHK = 4'd9;
  localparam logic [SWID-1:0] S_SCAN   = 4'd10;
  localparam logic [SWID-1:0] S_DRAIN  = 4'd11;
  localparam logic [SWID-1:0] S_DONE   = 4'd12;

  logic [SWID-1:0] state_r;

  // Configuration registers.
  logic [gbnp_pkg::SCALE_W-1:0]    scale_r;
  logic [gbnp_pkg::GRID_REG_W-1:0] cols_r, rows_r;
  logic [CW-1:0]                   cols_eff, rows_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= gbnp_pkg::SCALE_RST;
      cols_r  <= gbnp_pkg::COLS_RST;
      rows_r  <= gbnp_pkg::ROWS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbnp_pkg::CFG_SCALE: scale_r <= cfg_data;
        gbnp_pkg::CFG_COLS:  cols_r  <= cfg_data[gbnp_pkg::GRID_REG_W-1:0];
        gbnp_pkg::CFG_ROWS:  rows_r  <= cfg_data[gbnp_pkg::GRID_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero size acts as one, and a size above GRID_MAX acts as GRID_MAX.
  always_comb begin
    if (cols_r == '0) begin
      cols_eff = CW'(1);
    end else if (32'(cols_r) > GRID_MAX) begin
      cols_eff = CW'(GRID_MAX);
    end else begin
      cols_eff = CW'(cols_r);
    end
    if (rows_r == '0) begin
      rows_eff = CW'(1);
    end else if (32'(rows_r) > GRID_MAX) begin
      rows_eff = CW'(GRID_MAX);
    end else begin
      rows_eff = CW'(rows_r);
    end
  end

  // Captured beat.
  logic [gbnp_pkg::OP_W-1:0]    op_r;
  logic [gbnp_pkg::COORD_W-1:0] x_r, y_r;
  logic [gbnp_pkg::ID_W-1:0]    id_r;
  logic [gbnp_pkg::KIND_W-1:0]  kind_r;
  logic                         in_acc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_ch.operation;
      x_r    <= in_ch.pos_x;
      y_r    <= in_ch.pos_y;
      id_r   <= in_ch.point_id;
      kind_r <= in_ch.end_kind;
    end
  end

  // Cell index: Q4.12 times Q8.8, keeping the integer part of the Q12.20 product.
  logic [gbnp_pkg::PROD_W-1:0] prod_x, prod_y;
  logic [gbnp_pkg::CELL_W-1:0] ca_r, cb_r;

  assign prod_x = x_r * scale_r;
  assign prod_y = y_r * scale_r;

  always_ff @(posedge clk) begin
    if (state_r == S_CELL) begin
      ca_r <= prod_x[gbnp_pkg::PROD_W-1:gbnp_pkg::CELL_SHIFT];
      cb_r <= prod_y[gbnp_pkg::PROD_W-1:gbnp_pkg::CELL_SHIFT];
    end
  end

  // Shared remainder unit, first for x against the columns, then for y against the rows.
  logic                        mod_start;
  logic [gbnp_pkg::CELL_W-1:0] mod_dividend;
  logic [CW-1:0]               mod_divisor;
  logic                        mod_done;
  logic [CW-1:0]               mod_rem;
  logic [CW-1:0]               mx_r, my_r;

  assign mod_start    = ((state_r == S_DISP) && (op_r == gbnp_pkg::OP_FIND)) ||
                        ((state_r == S_MODX) && mod_done);
  assign mod_dividend = (state_r == S_DISP) ? ca_r : cb_r;
  assign mod_divisor  = (state_r == S_DISP) ? cols_eff : rows_eff;

  gbnp_mod_unit #(.GRID_MAX(GRID_MAX)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Neighbor cell selection with toroidal wrap.
  logic [1:0]    da_r, db_r;
  logic [CW-1:0] a_sel, b_sel;
  logic [CW-1:0] mx_dec, mx_inc, my_dec, my_inc;

  always_comb begin
    mx_dec = (mx_r == '0) ? cols_eff - CW'(1) : mx_r - CW'(1);
    mx_inc = (mx_r + CW'(1) == cols_eff) ? '0 : mx_r + CW'(1);
    my_dec = (my_r == '0) ? rows_eff - CW'(1) : my_r - CW'(1);
    my_inc = (my_r + CW'(1) == rows_eff) ? '0 : my_r + CW'(1);
    unique case (da_r)
      2'd0:    a_sel = mx_dec;
      2'd1:    a_sel = mx_r;
      default: a_sel = mx_inc;
    endcase
    unique case (db_r)
      2'd0:    b_sel = my_dec;
      2'd1:    b_sel = my_r;
      default: b_sel = my_inc;
    endcase
  end

  // Fill-count memory.
  logic [FW-1:0]  fill_mem [FDEPTH];
  logic           fill_we, fill_re;
  logic [FAW-1:0] fill_waddr, fill_raddr;
  logic [FW-1:0]  fill_wdata, fill_q_r, fill_n;
  logic [FAW:0]   clr_cnt_r;
  logic           clr_reply_r;

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (fill_re) begin
      fill_q_r <= fill_mem[fill_raddr];
    end
  end

  // Entry memory.
  gbnp_pkg::entry_t ent_mem [EDEPTH];
  gbnp_pkg::entry_t ent_wdata, ent_q_r;
  logic             ent_we, ent_re;
  logic [EAW-1:0]   ent_waddr, ent_raddr;
  logic [SW-1:0]    slot_r;
  logic             v1_r;

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_q_r <= ent_mem[ent_raddr];
    end
  end

  logic ins_full, outside;

  always_comb begin
    fill_n   = (32'(fill_q_r) > BUCKET_DEPTH) ? FW'(BUCKET_DEPTH) : fill_q_r;
    ins_full = (32'(fill_q_r) >= BUCKET_DEPTH);
    outside  = (32'(ca_r) >= 32'(cols_eff)) || (32'(cb_r) >= 32'(rows_eff));

    fill_we    = 1'b0;
    fill_waddr = {ca_r[GW-1:0], cb_r[GW-1:0]};
    fill_wdata = FW'(fill_q_r + FW'(1));
    if (state_r == S_CLR) begin
      fill_we    = 1'b1;
      fill_waddr = clr_cnt_r[FAW-1:0];
      fill_wdata = '0;
    end else if ((state_r == S_INS_WR) && !ins_full) begin
      fill_we = 1'b1;
    end

    fill_re    = (state_r == S_INS_RD) || (state_r == S_BK_RD);
    fill_raddr = (state_r == S_INS_RD) ? {ca_r[GW-1:0], cb_r[GW-1:0]}
                                       : {a_sel[GW-1:0], b_sel[GW-1:0]};

    ent_we    = (state_r == S_INS_WR) && !ins_full;
    ent_waddr = {ca_r[GW-1:0], cb_r[GW-1:0], fill_q_r[SW-1:0]};
    ent_wdata = '{px: x_r, py: y_r, id: id_r, kind: kind_r};

    ent_re    = (state_r == S_SCAN);
    ent_raddr = {a_sel[GW-1:0], b_sel[GW-1:0], slot_r};
  end

  // Distance pipeline.
  logic            dist_clear, dist_busy;
  gbnp_pkg::best_t best;

  assign dist_clear = (state_r == S_DISP);

  gbnp_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (dist_clear),
    .ent_vld (v1_r),
    .ent     (ent_q_r),
    .qx      (x_r),
    .qy      (y_r),
    .busy    (dist_busy),
    .best    (best)
  );

  // Result register.
  logic [gbnp_pkg::STAT_W-1:0] res_stat_r;
  logic                        out_valid_r;
  logic [gbnp_pkg::STAT_W-1:0] out_status_r;
  gbnp_pkg::best_t             out_best_r;
  logic                        last_bk;
  logic [FW-1:0]               slot_init;

  assign last_bk   = (da_r == 2'd2) && (db_r == 2'd2);
  assign slot_init = fill_n - FW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      da_r        <= '0;
      db_r        <= '0;
    end else begin
      v1_r <= ent_re;
      if ((state_r == S_DONE) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_CELL;
          end
        end
        S_CLR: begin
          clr_cnt_r <= clr_cnt_r + (FAW+1)'(1);
          if (clr_cnt_r == (FAW+1)'(FDEPTH - 1)) begin
            state_r <= clr_reply_r ? S_DONE : S_IDLE;
          end
        end
        S_CELL: begin
          state_r <= S_DISP;
        end
        S_DISP: begin
          priority if (op_r == gbnp_pkg::OP_CLEAR) begin
            res_stat_r  <= gbnp_pkg::STAT_DONE;
            clr_cnt_r   <= '0;
            clr_reply_r <= 1'b1;
            state_r     <= S_CLR;
          end else if (op_r == gbnp_pkg::OP_INSERT) begin
            if (outside) begin
              res_stat_r <= gbnp_pkg::STAT_OUTSIDE;
              state_r    <= S_DONE;
            end else begin
              res_stat_r <= gbnp_pkg::STAT_DONE;
              state_r    <= S_INS_RD;
            end
          end else if (op_r == gbnp_pkg::OP_FIND) begin
            res_stat_r <= gbnp_pkg::STAT_DONE;
            state_r    <= S_MODX;
          end else begin
            res_stat_r <= gbnp_pkg::STAT_DONE;
            state_r    <= S_DONE;
          end
        end
        S_INS_RD: begin
          state_r <= S_INS_WR;
        end
        S_INS_WR: begin
          if (ins_full) begin
            res_stat_r <= gbnp_pkg::STAT_FULL;
          end
          state_r <= S_DONE;
        end
        S_MODX: begin
          if (mod_done) begin
            mx_r    <= mod_rem;
            state_r <= S_MODY;
          end
        end
        S_MODY: begin
          if (mod_done) begin
            my_r    <= mod_rem;
            da_r    <= '0;
            db_r    <= '0;
            state_r <= S_BK_RD;
          end
        end
        S_BK_RD: begin
          state_r <= S_BK_CHK;
        end
        S_BK_CHK, S_SCAN: begin
          if ((state_r == S_BK_CHK) && (fill_n != '0)) begin
            // Newest entry first: the scan starts at the highest filled slot.
            slot_r  <= slot_init[SW-1:0];
            state_r <= S_SCAN;
          end else if ((state_r == S_SCAN) && (slot_r != '0)) begin
            slot_r <= slot_r - SW'(1);
          end else if (last_bk) begin
            state_r <= S_DRAIN;
          end else begin
            if (db_r == 2'd2) begin
              db_r <= '0;
              da_r <= da_r + 2'd1;
            end else begin
              db_r <= db_r + 2'd1;
            end
            state_r <= S_BK_RD;
          end
        end
        S_DRAIN: begin
          if (!v1_r && !dist_busy) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_status_r <= (op_r == gbnp_pkg::OP_FIND) ? gbnp_pkg::STAT_DONE : res_stat_r;
            out_best_r   <= (op_r == gbnp_pkg::OP_FIND) ? best : '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.found       = out_best_r.found;
  assign out_ch.nearest_id  = out_best_r.ent.id;
  assign out_ch.nearest_end = out_best_r.ent.kind;
  assign out_ch.nearest_x   = out_best_r.ent.px;
  assign out_ch.nearest_y   = out_best_r.ent.py;
  assign out_ch.dist_sq     = out_best_r.dsq;

endmodule

>>> src/gbnp_checker.sv
// Port-level checks of the grid bucket block, bound to the top level.
`include "grid_bucket_nearest_point_top_defines.svh"

module gbnp_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [gbnp_pkg::STAT_W-1:0]  out_status,
  input logic                         out_found,
  input logic [gbnp_pkg::ID_W-1:0]    out_id,
  input logic [gbnp_pkg::COORD_W-1:0] out_x,
  input logic [gbnp_pkg::DIST_W-1:0]  out_dist
);

  // The block works on one beat at a time, so ready drops after every accepted beat.
  `GBNP_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "ready stayed high after accept")
  // A result without a found point carries zero fields.
  `GBNP_ASSERT_SAME(a_empty_zero, out_valid && !out_found, (out_dist == '0) && (out_id == '0) && (out_x == '0), "nonzero fields without a point")
  // Only a successful find reports a point.
  `GBNP_ASSERT_SAME(a_status_found, out_valid && (out_status != gbnp_pkg::STAT_DONE), !out_found, "dropped insert reports a point")
  `GBNP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat withdrawn")
  `GBNP_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_dist) && $stable(out_status), "stalled result changed")

endmodule

bind grid_bucket_nearest_point_top gbnp_checker u_gbnp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_found  (out_ch.found),
  .out_id     (out_ch.nearest_id),
  .out_x      (out_ch.nearest_x),
  .out_dist   (out_ch.dist_sq)
);

>>> verif/gbnp_result_checker.sv
// Monitor, predictor and scoreboard for the grid bucket nearest-point table.
module gbnp_result_checker
  import gbnp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  gbnp_in_if                   in_mon,
  gbnp_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                   mismatches,
  output int                   pending
);

  typedef struct {
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [ID_W-1:0]    id;
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [DIST_W-1:0]  dsq;
  } answer_t;

  localparam int NBUCKETS = GRID_MAX_DEF * GRID_MAX_DEF;

  logic [SCALE_W-1:0]    scale_reg;
  logic [GRID_REG_W-1:0] cols_reg;
  logic [GRID_REG_W-1:0] rows_reg;
  int                    fill_cnt [NBUCKETS];
  entry_t                points [NBUCKETS * BUCKET_DEPTH_DEF];
  answer_t               answers_q [$];

  function automatic int clamp_grid(logic [GRID_REG_W-1:0] v);
    if (v == 0) return 1;
    if (v > GRID_MAX_DEF) return GRID_MAX_DEF;
    return int'(v);
  endfunction

  function automatic int cell_index(logic [COORD_W-1:0] c);
    return int'((longint'(c) * longint'(scale_reg)) >> CELL_SHIFT);
  endfunction

  // Applies one operation to the shadow table and returns its answer.
  function automatic answer_t apply_op(logic [OP_W-1:0] op, logic [COORD_W-1:0] x,
                                       logic [COORD_W-1:0] y, logic [ID_W-1:0] pid,
                                       logic [KIND_W-1:0] knd);
    answer_t r;
    int      cols, rows, ca, cb, a, b, bk, n;
    longint  dx, dy, d;
    entry_t  e;
    r = '{default: '0};
    cols = clamp_grid(cols_reg);
    rows = clamp_grid(rows_reg);
    ca = cell_index(x);
    cb = cell_index(y);
    if (op == OP_CLEAR) begin
      foreach (fill_cnt[i]) fill_cnt[i] = 0;
    end else if (op == OP_INSERT) begin
      if (ca >= cols || cb >= rows) begin
        r.status = STAT_OUTSIDE;
      end else begin
        bk = ca * GRID_MAX_DEF + cb;
        if (fill_cnt[bk] >= BUCKET_DEPTH_DEF) begin
          r.status = STAT_FULL;
        end else begin
          points[bk * BUCKET_DEPTH_DEF + fill_cnt[bk]] = '{px: x, py: y, id: pid, kind: knd};
          fill_cnt[bk]++;
        end
      end
    end else if (op == OP_FIND) begin
      for (int da = 0; da < 3; da++) begin
        a = (ca + cols + da - 1) % cols;
        for (int db = 0; db < 3; db++) begin
          b = (cb + rows + db - 1) % rows;
          bk = a * GRID_MAX_DEF + b;
          n = fill_cnt[bk];
          // Newest entry first; only a strictly closer point takes over.
          while (n > 0) begin
            n--;
            e = points[bk * BUCKET_DEPTH_DEF + n];
            dx = longint'(x) - longint'(e.px);
            dy = longint'(y) - longint'(e.py);
            d = dx * dx + dy * dy;
            if (!r.found || d < longint'(r.dsq)) begin
              r.found = 1'b1;
              r.dsq = d[DIST_W-1:0];
              r.id = e.id;
              r.kind = e.kind;
              r.px = e.px;
              r.py = e.py;
            end
          end
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("result field %s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  assign pending = answers_q.size();

  initial mismatches = 0;

  always @(posedge clk) begin
    answer_t w;
    if (!rst_n) begin
      scale_reg <= SCALE_RST;
      cols_reg <= COLS_RST;
      rows_reg <= ROWS_RST;
      foreach (fill_cnt[i]) fill_cnt[i] = 0;
      foreach (points[i]) points[i] = '0;
      answers_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready)
        answers_q.push_back(apply_op(in_mon.operation, in_mon.pos_x, in_mon.pos_y,
                                     in_mon.point_id, in_mon.end_kind));
      if (out_mon.valid && out_mon.ready) begin
        if (answers_q.size() == 0) begin
          $error("result beat arrived with no operation outstanding");
          mismatches++;
        end else begin
          w = answers_q.pop_front();
          check_field("status", w.status, out_mon.status);
          check_field("found", w.found, out_mon.found);
          check_field("nearest_id", w.id, out_mon.nearest_id);
          check_field("nearest_end", w.kind, out_mon.nearest_end);
          check_field("nearest_x", w.px, out_mon.nearest_x);
          check_field("nearest_y", w.py, out_mon.nearest_y);
          check_field("dist_sq", w.dsq, out_mon.dist_sq);
        end
      end
      // Register writes take effect for beats accepted after this edge.
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
          CFG_COLS:  cols_reg <= cfg_data[GRID_REG_W-1:0];
          CFG_ROWS:  rows_reg <= cfg_data[GRID_REG_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

>>> verif/tb_grid_bucket_nearest_point_top.sv
// Stimulus and verdict for the grid bucket nearest-point table.
module tb_grid_bucket_nearest_point_top;
  import gbnp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gbnp_in_if  in_ch();
  gbnp_out_if out_ch();

  logic                  snd_valid = 1'b0;
  logic [OP_W-1:0]       snd_op = OP_CLEAR;
  logic [COORD_W-1:0]    snd_x = '0;
  logic [COORD_W-1:0]    snd_y = '0;
  logic [ID_W-1:0]       snd_id = '0;
  logic [KIND_W-1:0]     snd_kind = '0;
  logic                  rcv_ready = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SCALE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  assign in_ch.valid = snd_valid;
  assign in_ch.operation = snd_op;
  assign in_ch.pos_x = snd_x;
  assign in_ch.pos_y = snd_y;
  assign in_ch.point_id = snd_id;
  assign in_ch.end_kind = snd_kind;
  assign out_ch.ready = rcv_ready;

  int mismatches, pending;
  int n_sent = 0;
  int n_rcvd = 0;
  bit quiet = 1'b0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;

  int scale_now = 2048;
  int cols_now = 8;
  int rows_now = 8;
  logic [COORD_W-1:0] last_x = '0;
  logic [COORD_W-1:0] last_y = '0;

  grid_bucket_nearest_point_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  gbnp_result_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off to back the block up.
  always @(posedge clk) begin
    if (out_ch.valid && rcv_ready) n_rcvd++;
    if (hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (!rst_n) begin
      rcv_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rcv_ready <= 1'b0;
    end else begin
      rcv_ready <= quiet || ($urandom_range(99) >= 12);
    end
  end

  task automatic send_beat(logic [OP_W-1:0] op, logic [COORD_W-1:0] x,
                           logic [COORD_W-1:0] y, logic [ID_W-1:0] pid,
                           logic [KIND_W-1:0] knd);
    if (!quiet && $urandom_range(99) < 12) begin
      snd_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    snd_valid <= 1'b1;
    snd_op <= op;
    snd_x <= x;
    snd_y <= y;
    snd_id <= pid;
    snd_kind <= knd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
    if (op == OP_INSERT) begin
      last_x = x;
      last_y = y;
    end
  endtask

  task automatic drain;
    snd_valid <= 1'b0;
    while (n_rcvd != n_sent) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic set_grid(int scale, int cols, int rows);
    write_reg(CFG_SCALE, scale);
    write_reg(CFG_COLS, cols);
    write_reg(CFG_ROWS, rows);
    cfg_we <= 1'b0;
    @(posedge clk);
    scale_now = scale;
    cols_now = (cols == 0) ? 1 : (cols > GRID_MAX_DEF ? GRID_MAX_DEF : cols);
    rows_now = (rows == 0) ? 1 : (rows > GRID_MAX_DEF ? GRID_MAX_DEF : rows);
  endtask

  // Largest coordinate that still lands inside the grid along one axis.
  function automatic int coord_limit(int cells);
    longint lim;
    lim = ((longint'(cells) << CELL_SHIFT) - 1) / scale_now;
    return (lim > 65535) ? 65535 : int'(lim);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord(int lim, bit hot);
    if ($urandom_range(9) == 0) return $urandom();
    if (hot) return $urandom_range(0, lim / 8);
    return $urandom_range(0, lim);
  endfunction

  task automatic random_beat(bit hot);
    int r;
    logic [OP_W-1:0] op;
    logic [COORD_W-1:0] x, y;
    r = $urandom_range(99);
    op = (r < 2) ? OP_CLEAR : (r < 52) ? OP_INSERT : (r < 97) ? OP_FIND : 2'd3;
    x = pick_coord(coord_limit(cols_now), hot);
    y = pick_coord(coord_limit(rows_now), hot);
    if (op == OP_FIND && $urandom_range(9) < 3) begin
      x = last_x + COORD_W'($urandom_range(0, 512)) - COORD_W'(256);
      y = last_y + COORD_W'($urandom_range(0, 512)) - COORD_W'(256);
    end
    send_beat(op, x, y, $urandom(), $urandom_range(3));
  endtask

  task automatic run_phase(int scale, int cols, int rows, int items);
    bit hot;
    drain();
    set_grid(scale, cols, rows);
    hot = $urandom_range(2) == 0;
    repeat (items) random_beat(hot);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset grid: 8x8 cells, 512 coordinate units per cell.
    send_beat(OP_FIND, 16'd100, 16'd100, 16'd0, 2'd0);
    send_beat(OP_INSERT, 16'd0, 16'd0, 16'd0, 2'd0);
    send_beat(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
    send_beat(OP_INSERT, 16'd4095, 16'd4095, 16'hFFFF, 2'd3);
    for (int i = 0; i < 9; i++)
      send_beat(OP_INSERT, 16'(1030 + 7 * i), 16'(1100 - 5 * i), 16'(16'h1000 + i), 2'(i));
    send_beat(OP_FIND, 16'd1050, 16'd1080, 16'd0, 2'd0);
    send_beat(OP_FIND, 16'd0, 16'd0, 16'd0, 2'd0);
    send_beat(OP_FIND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
    send_beat(OP_FIND, 16'd4000, 16'd100, 16'd0, 2'd0);
    send_beat(2'd3, 16'hAAAA, 16'h5555, 16'hFFFF, 2'd3);
    send_beat(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3);
    send_beat(OP_FIND, 16'd1050, 16'd1080, 16'd0, 2'd0);

    quiet = 1'b1;
    run_phase(65535, 64, 64, 170);
    quiet = 1'b0;
    run_phase(1024, 1, 1, 170);
    run_phase(1024, 0, 127, 170);
    run_phase(4096, 3, 2, 170);
    drain();
    set_grid(2048, 2, 5);
    hold_go = 1'b1;
    repeat (170) random_beat(1'b1);
    run_phase($urandom_range(1024, 65535), $urandom_range(1, 64), $urandom_range(1, 64), 170);
    run_phase($urandom_range(1024, 4096), $urandom_range(1, 16), $urandom_range(1, 16), 170);
    drain();
    repeat (200) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      if (pending != 0) $error("%0d expected results never arrived", pending);
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
